// ===== rtl/spi_baud_divisor_search_assert.svh =====
// Assertion macros for the baud divisor search block.
// Used by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef SPI_BAUD_DIVISOR_SEARCH_ASSERT_SVH
`define SPI_BAUD_DIVISOR_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define SPIBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("spibd assertion failed");
// Checked at every edge, reset included.
`define SPIBD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("spibd assertion failed");
`else
`define SPIBD_ASSERT(lbl, prop)
`define SPIBD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/spibd_pkg.sv =====
// Package for the baud divisor search: field widths, code limits and the
// controller-to-datapath command type. No dependencies.
`default_nettype none
package spibd_pkg;
    localparam int unsigned RATE_W     = 32;
    localparam int unsigned ACHIEVED_W = 31;
    localparam int unsigned PRE_W      = 3;
    localparam int unsigned DIV_W      = 4;
    localparam int unsigned BIT_W      = 5;   // counts the 32 divide steps
    localparam int unsigned REM_W      = 3;   // remainder stays below 8

    localparam logic [PRE_W-1:0]  PRESCALE_MAX = 3'd7;
    localparam logic [DIV_W-1:0]  DIVIDER_MAX  = 4'd8;
    localparam logic [BIT_W-1:0]  BIT_LAST     = 5'd31;
    localparam logic [RATE_W-1:0] CLK_RESET_HZ = 32'd24000000;

    typedef struct packed {
        logic             load;      // capture request, clear best pair
        logic             div_init;  // start clock / (p + 1)
        logic             div_step;  // one restoring divide step
        logic             cand;      // evaluate pair (p, d)
        logic             out_load;  // move best pair into the output register
        logic [PRE_W-1:0] p;
        logic [DIV_W-1:0] d;
    } t_cmd;
endpackage
`default_nettype wire

// ===== rtl/spibd_ctrl.sv =====
// Controller for the baud divisor search: handshakes, loop counters, commands.
// Depends on spibd_pkg and spi_baud_divisor_search_assert.svh.
`default_nettype none
`include "spi_baud_divisor_search_assert.svh"
module spibd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output spibd_pkg::t_cmd    o_cmd
);
    import spibd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_CAND, S_DONE} t_state;

    t_state           r_state, n_state;
    logic [PRE_W-1:0] r_p, n_p;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [DIV_W-1:0] r_d, n_d;
    logic             r_out_valid, n_out_valid;
    logic             c_accept;
    logic             c_out_free;

    assign c_accept    = (r_state == S_IDLE) && i_in_valid;
    assign c_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_bit       = r_bit;
        n_d         = r_d;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.p     = r_p;
        o_cmd.d     = r_d;
        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.div_init = 1'b1;
                    n_p            = '0;
                    n_bit          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + 1'b1;
                if (r_bit == BIT_LAST) begin
                    n_d     = '0;
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                o_cmd.cand = 1'b1;
                n_d        = r_d + 1'b1;
                if (r_d == DIVIDER_MAX) begin
                    if (r_p == PRESCALE_MAX) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_p            = r_p + 1'b1;
                        n_bit          = '0;
                        n_state        = S_DIV;
                    end
                end
            end
            S_DONE: begin
                if (c_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p         <= '0;
            r_bit       <= '0;
            r_d         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_bit       <= n_bit;
            r_d         <= n_d;
            r_out_valid <= n_out_valid;
        end
    end

    `SPIBD_ASSERT(a_accept_starts_div, c_accept |=> (r_state == S_DIV && r_bit == '0))
    `SPIBD_ASSERT(a_div_runs_full, (r_state == S_DIV && r_bit != BIT_LAST) |=> r_state == S_DIV)
    `SPIBD_ASSERT(a_out_load_valid, o_cmd.out_load |=> (r_out_valid && r_state == S_IDLE))
    `SPIBD_ASSERT(a_d_in_range, r_d <= DIVIDER_MAX + 4'd1)
endmodule
`default_nettype wire

// ===== rtl/spibd_dp.sv =====
// Datapath for the baud divisor search: clock register, bit-serial divide by
// p + 1, candidate compare and best-pair tracking, output register. Uses spibd_pkg.
`default_nettype none
module spibd_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [spibd_pkg::RATE_W-1:0]    i_cfg_wdata,
    input  wire logic [spibd_pkg::RATE_W-1:0]    i_desired_rate,
    input  wire spibd_pkg::t_cmd                 i_cmd,
    output logic [spibd_pkg::PRE_W-1:0]          o_prescale_code,
    output logic [spibd_pkg::DIV_W-1:0]          o_divider_code,
    output logic [spibd_pkg::ACHIEVED_W-1:0]     o_achieved_rate,
    output logic                                 o_found
);
    import spibd_pkg::*;

    logic [RATE_W-1:0]     r_clk_hz;
    logic [RATE_W-1:0]     r_req;
    logic [RATE_W-1:0]     r_quo;      // dividend shifts out, quotient shifts in
    logic [REM_W-1:0]      r_rem;
    logic                  r_have;
    logic [RATE_W-1:0]     r_best_short;
    logic [PRE_W-1:0]      r_best_p;
    logic [DIV_W-1:0]      r_best_d;
    logic [ACHIEVED_W-1:0] r_best_rate;
    logic [PRE_W-1:0]      r_o_p;
    logic [DIV_W-1:0]      r_o_d;
    logic [ACHIEVED_W-1:0] r_o_rate;
    logic                  r_o_found;

    logic [DIV_W-1:0]      c_divisor;
    logic [REM_W:0]        c_trial;
    logic                  c_qbit;
    logic [REM_W:0]        c_diff;
    logic [DIV_W-1:0]      c_shamt;
    logic [RATE_W-1:0]     c_rate;
    logic [RATE_W-1:0]     c_short;
    logic                  c_take;

    // restoring step: divisor is 1..8, so the partial remainder fits in 3 bits
    assign c_divisor = {1'b0, i_cmd.p} + 4'd1;
    assign c_trial   = {r_rem, r_quo[RATE_W-1]};
    assign c_qbit    = (c_trial >= c_divisor);
    assign c_diff    = c_trial - c_divisor;

    // floor(floor(clk/(p+1)) / 2^(d+1)) equals floor(clk/((p+1)*2^(d+1)))
    assign c_shamt = i_cmd.d + 4'd1;
    assign c_rate  = r_quo >> c_shamt;
    assign c_short = r_req - c_rate;
    assign c_take  = (r_req >= c_rate) && (!r_have || (c_short < r_best_short));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz  <= CLK_RESET_HZ;
            r_have    <= 1'b0;
            r_o_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_have <= 1'b0;
            end else if (i_cmd.cand && c_take) begin
                r_have <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_o_found <= r_have;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req       <= i_desired_rate;
            r_best_p    <= '0;
            r_best_d    <= '0;
            r_best_rate <= '0;
        end else if (i_cmd.cand && c_take) begin
            r_best_short <= c_short;
            r_best_p     <= i_cmd.p;
            r_best_d     <= i_cmd.d;
            r_best_rate  <= c_rate[ACHIEVED_W-1:0];
        end
        if (i_cmd.div_init) begin
            r_quo <= r_clk_hz;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[RATE_W-2:0], c_qbit};
            r_rem <= c_qbit ? c_diff[REM_W-1:0] : c_trial[REM_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_p    <= r_best_p;
            r_o_d    <= r_best_d;
            r_o_rate <= r_best_rate;
        end
    end

    assign o_prescale_code = r_o_p;
    assign o_divider_code  = r_o_d;
    assign o_achieved_rate = r_o_rate;
    assign o_found         = r_o_found;
endmodule
`default_nettype wire

// ===== rtl/spi_baud_divisor_search.sv =====
// Sequence from input transfer to output valid: for each of the 8
//   prescaler codes a 32-step bit-serial divide of the clock by p+1 is followed by
//   one candidate evaluation per divider code (0 to 8), then the output is loaded.
// A new request is taken only after the result is loaded; input stalls from transfer until
//   that load, which waits while the previous result still sits stalled in the output.
// Reset (i_rst_n low, synchronous): idle, no output valid, clock register 24 MHz.
`default_nettype none
module spi_baud_divisor_search (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration: source clock in Hz, write only while idle
    input  wire logic                            i_cfg_we,
    input  wire logic [spibd_pkg::RATE_W-1:0]    i_cfg_wdata,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [spibd_pkg::RATE_W-1:0]    i_desired_rate,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [spibd_pkg::PRE_W-1:0]          o_prescale_code,
    output logic [spibd_pkg::DIV_W-1:0]          o_divider_code,
    output logic [spibd_pkg::ACHIEVED_W-1:0]     o_achieved_rate,
    output logic                                 o_found
);
    import spibd_pkg::*;

    // command bundle: controller sequences the loops, datapath does the math
    t_cmd w_cmd;

    // Controller: request/result transfers, prescaler, divide-step and
    // divider-code counters.
    spibd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // Datapath: rate = (clk / (p+1)) >> (d+1); keeps the first pair with the
    // strictly smallest shortfall not above the request, tracked with a valid bit.
    spibd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_desired_rate  (i_desired_rate),
        .i_cmd           (w_cmd),
        .o_prescale_code (o_prescale_code),
        .o_divider_code  (o_divider_code),
        .o_achieved_rate (o_achieved_rate),
        .o_found         (o_found)
    );
endmodule
`default_nettype wire
